// File: hdl/cdg_pkg.sv
`timescale 1ns / 1ps

package cdg_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 9;
  localparam int POS_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION_MODE = 2'd0,
    REG_IMAGE_WIDTH    = 2'd1,
    REG_IMAGE_HEIGHT   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_X = 1'b0,
    MODE_Y = 1'b1
  } dir_mode_t;

  typedef enum logic {
    PH_FIRST  = 1'b0,
    PH_SECOND = 1'b1
  } back_phase_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
  } cdg_result_t;

  // one accepted pixel, up to two results
  typedef struct packed {
    logic        has_a;
    cdg_result_t res_a;
    logic        has_b;
    cdg_result_t res_b;
    logic        done_b;
  } cdg_entry_t;

  typedef struct packed {
    logic       valid;
    cdg_entry_t entry;
  } cdg_push_t;

  typedef struct packed {
    logic full;
    logic almost_full;
    logic empty;
  } cdg_fifo_status_t;

endpackage

// File: hdl/cdg_if.sv
`timescale 1ns / 1ps

interface cdg_pixel_if import cdg_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface cdg_result_if import cdg_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] gradient_half;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_column;
  logic                     last_of_run;
  logic                     frame_done;

  modport source (output valid, output gradient_half, output out_row, output out_column,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input gradient_half, input out_row, input out_column,
                input last_of_run, input frame_done, output ready);
endinterface

interface cdg_cfg_if import cdg_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/cdg_ram.sv
`timescale 1ns / 1ps

module cdg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/cdg_front.sv
`timescale 1ns / 1ps

module cdg_front import cdg_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  cdg_pixel_if.sink        pixels,
  cdg_cfg_if.sink          cfg,
  output cdg_push_t        push,
  input  cdg_fifo_status_t status
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  function automatic int last_index(input logic [CFG_DATA_W-1:0] v, input int max_v);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > max_v) n = max_v;
    return n - 1;
  endfunction

  function automatic logic signed [GRAD_W-1:0] pix_diff(input logic [PIX_W-1:0] a,
                                                        input logic [PIX_W-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  dir_mode_t        mode;
  logic [CW-1:0]    width_last;
  logic [RW-1:0]    height_last;
  logic [CW-1:0]    column_count;
  logic [RW-1:0]    row_count;
  logic [PIX_W-1:0] pixel_prev;
  logic [PIX_W-1:0] pixel_prev_prev;

  logic [CW-1:0] c;
  logic [RW-1:0] r;
  logic          last_c;
  logic          last_r;
  logic          accept;

  // stage 1: line buffer data arrives
  logic             s1_valid;
  dir_mode_t        s1_mode;
  logic [PIX_W-1:0] s1_pix;
  logic [PIX_W-1:0] s1_pp;
  logic [PIX_W-1:0] s1_ppp;
  logic [CW-1:0]    s1_c;
  logic [RW-1:0]    s1_r;
  logic             s1_last_c;
  logic             s1_last_r;

  logic             byp_valid;
  logic [CW-1:0]    byp_addr;
  logic [PIX_W-1:0] byp_prev;
  logic [PIX_W-1:0] byp_pp;

  logic [PIX_W-1:0] rd_prev;
  logic [PIX_W-1:0] rd_pp;
  logic [PIX_W-1:0] prev_eff;
  logic [PIX_W-1:0] pp_eff;
  logic             byp_hit;

  logic c_ge1, c_ge2, r_ge1, r_ge2;
  cdg_entry_t entry;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_X;
      width_last  <= CW'(RST_W - 1);
      height_last <= RW'(RST_H - 1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DIRECTION_MODE: mode        <= dir_mode_t'(cfg.data[0]);
        REG_IMAGE_WIDTH:    width_last  <= CW'(last_index(cfg.data, MAX_WIDTH));
        REG_IMAGE_HEIGHT:   height_last <= RW'(last_index(cfg.data, MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // room for the item in flight as well as the new one
  assign pixels.ready = !rst && !status.full && !(status.almost_full && s1_valid);
  assign accept       = pixels.valid && pixels.ready;

  // counters saturate to the current size
  assign c      = (column_count > width_last) ? width_last : column_count;
  assign r      = (row_count > height_last) ? height_last : row_count;
  assign last_c = (c == width_last);
  assign last_r = (r == height_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      pixel_prev      <= '0;
      pixel_prev_prev <= '0;
    end else if (accept) begin
      pixel_prev_prev <= pixel_prev;
      pixel_prev      <= pixels.pixel;
      if (last_c) begin
        column_count <= '0;
        row_count    <= last_r ? '0 : r + 1'b1;
      end else begin
        column_count <= c + 1'b1;
        row_count    <= r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode   <= mode;
      s1_pix    <= pixels.pixel;
      s1_pp     <= pixel_prev;
      s1_ppp    <= pixel_prev_prev;
      s1_c      <= c;
      s1_r      <= r;
      s1_last_c <= last_c;
      s1_last_r <= last_r;
    end
  end

  cdg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_prev (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_c),
    .wdata (s1_pix),
    .re    (accept),
    .raddr (c),
    .rdata (rd_prev)
  );

  cdg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_prev_prev (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_c),
    .wdata (prev_eff),
    .re    (accept),
    .raddr (c),
    .rdata (rd_pp)
  );

  // the last write may land on the column just read (one-column images)
  assign byp_hit  = byp_valid && (byp_addr == s1_c);
  assign prev_eff = byp_hit ? byp_prev : rd_prev;
  assign pp_eff   = byp_hit ? byp_pp : rd_pp;

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (s1_valid) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      byp_addr <= s1_c;
      byp_prev <= s1_pix;
      byp_pp   <= prev_eff;
    end
  end

  assign c_ge1 = int'(s1_c) >= 1;
  assign c_ge2 = int'(s1_c) >= 2;
  assign r_ge1 = int'(s1_r) >= 1;
  assign r_ge2 = int'(s1_r) >= 2;

  always_comb begin
    entry        = '0;
    entry.done_b = s1_last_c && s1_last_r;
    if (s1_mode == MODE_X) begin
      entry.has_a      = c_ge1;
      entry.res_a.grad = pix_diff(s1_pix, c_ge2 ? s1_ppp : s1_pp);
      entry.res_a.row  = POS_W'(s1_r);
      entry.res_a.col  = POS_W'(s1_c - 1'b1);
      entry.has_b      = s1_last_c;
      entry.res_b.grad = pix_diff(s1_pix, c_ge1 ? s1_pp : s1_pix);
      entry.res_b.row  = POS_W'(s1_r);
      entry.res_b.col  = POS_W'(s1_c);
    end else begin
      entry.has_a      = r_ge1;
      entry.res_a.grad = pix_diff(s1_pix, r_ge2 ? pp_eff : prev_eff);
      entry.res_a.row  = POS_W'(s1_r - 1'b1);
      entry.res_a.col  = POS_W'(s1_c);
      entry.has_b      = s1_last_r;
      entry.res_b.grad = pix_diff(s1_pix, r_ge1 ? prev_eff : s1_pix);
      entry.res_b.row  = POS_W'(s1_r);
      entry.res_b.col  = POS_W'(s1_c);
    end
  end

  assign push.valid = s1_valid && (entry.has_a || entry.has_b);
  assign push.entry = entry;

endmodule

// File: hdl/cdg_fifo.sv
`timescale 1ns / 1ps

module cdg_fifo import cdg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  cdg_push_t        push,
  input  logic             pop,
  output cdg_entry_t       head,
  output cdg_fifo_status_t status
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  cdg_entry_t    entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.entry;
    end
  end

  assign head               = entries[rd_ptr];
  assign status.full        = (count == NW'(DEPTH));
  assign status.almost_full = (count == NW'(DEPTH - 1));
  assign status.empty       = (count == '0);

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !status.full)
    else $error("transaction pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from an empty queue");
`endif

endmodule

// File: hdl/cdg_back.sv
`timescale 1ns / 1ps

module cdg_back import cdg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cdg_entry_t       head,
  input  cdg_fifo_status_t status,
  output logic             pop,
  cdg_result_if.source     results
);

  back_phase_t phase;
  back_phase_t phase_next;
  logic        load;
  logic        head_ok;
  logic        emit;
  logic        sel_b;

  assign load    = !results.valid || results.ready;
  assign head_ok = !status.empty;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_FIRST: begin
        if (load && head_ok && head.has_a && head.has_b) phase_next = PH_SECOND;
      end
      PH_SECOND: begin
        if (load && head_ok) phase_next = PH_FIRST;
      end
      default: phase_next = PH_FIRST;
    endcase
  end

  always_comb begin
    emit  = 1'b0;
    sel_b = 1'b0;
    pop   = 1'b0;
    unique case (phase)
      PH_FIRST: begin
        emit  = load && head_ok;
        sel_b = !head.has_a;
        pop   = emit && !(head.has_a && head.has_b);
      end
      PH_SECOND: begin
        emit  = load && head_ok;
        sel_b = 1'b1;
        pop   = emit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      results.gradient_half <= sel_b ? head.res_b.grad : head.res_a.grad;
      results.out_row       <= sel_b ? head.res_b.row : head.res_a.row;
      results.out_column    <= sel_b ? head.res_b.col : head.res_a.col;
      results.last_of_run   <= sel_b || !head.has_b;
      results.frame_done    <= sel_b && head.done_b;
    end
  end

`ifndef NO_ASSERTIONS
  // the second result of a pair follows without a gap
  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && !results.last_of_run |=> results.valid)
    else $error("result run broken after a non-final transaction");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.frame_done |-> results.last_of_run)
    else $error("frame end flagged on a non-final result");

  a_second_has_head: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SECOND |-> !status.empty)
    else $error("second result pending with no queued entry");
`endif

endmodule

// File: hdl/central_difference_gradient.sv
`timescale 1ns / 1ps

// Central-difference gradient of an 8-bit raster image with replicate border,
// along x or y as the direction mode register selects. Pixels are taken at one
// per clock while the queue has room; each result is forward minus backward
// neighbour (gradient times two). Results trail the input by one pixel in x
// mode and one row in y mode; the pixel closing a row (x) or in the last row
// (y) yields up to two results, which the output side delivers back to back
// while the output accepts, so a sustained stream is limited to one result per
// clock at the output register. After a pixel is accepted, the line buffer data
// returns and its results are formed and queued; the queue head then moves into
// the output register. The two line buffers are simple dual-port RAMs of
// MAX_WIDTH bytes, read at the incoming column and rewritten in the cycle after;
// a four-entry queue decouples input and output.
// There is no clearing pass after reset. Write the size and mode registers
// only between frames.
module central_difference_gradient import cdg_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic         clk,
  input  logic         rst,
  cdg_pixel_if.sink    pixels,
  cdg_result_if.source results,
  cdg_cfg_if.sink      cfg
);

  cdg_push_t        push;
  cdg_entry_t       head;
  cdg_fifo_status_t status;
  logic             pop;

  cdg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels),
    .cfg    (cfg),
    .push   (push),
    .status (status)
  );

  cdg_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (status)
  );

  cdg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .status  (status),
    .pop     (pop),
    .results (results)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import cdg_pkg::*;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic                     last;
    logic                     done;
  } grad_result_t;

  logic clk = 1'b0;
  logic rst;

  cdg_pixel_if  pix_bus();
  cdg_result_if grad_bus();
  cdg_cfg_if    reg_bus();

  central_difference_gradient uut (
    .clk(clk),
    .rst(rst),
    .pixels(pix_bus),
    .results(grad_bus),
    .cfg(reg_bus)
  );

  always #1 clk = ~clk;

  logic [PIX_W-1:0] pending_px[$];
  logic [PIX_W-1:0] directed_px[$];
  grad_result_t     expected_grads[$];
  bit               failed = 1'b0;
  bit               no_idle = 1'b0;
  int               gap_left;
  int               stall_left;

  // shadow of the block's registers and image state
  dir_mode_t         mode_q;
  logic [10:0]       width_q;
  logic [10:0]       height_q;
  logic [PIX_W-1:0]  line_above [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]  line_above2 [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]  px_last;
  logic [PIX_W-1:0]  px_last2;
  int                col_pos;
  int                row_pos;

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int eff_dim(input logic [10:0] v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] next_pixel();
    if (directed_px.size() != 0) return directed_px.pop_front();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic grad_result_t grad_entry(input int g, input int r, input int c,
                                              input logic done);
    grad_result_t e;
    e.grad = GRAD_W'(g);
    e.row  = POS_W'(r);
    e.col  = POS_W'(c);
    e.last = 1'b0;
    e.done = done;
    return e;
  endfunction

  task automatic predict_gradient(input logic [PIX_W-1:0] px);
    int w, h, c, r, p, nb, n0;
    bit lc, lr;
    w = eff_dim(width_q, DEF_MAX_WIDTH);
    h = eff_dim(height_q, DEF_MAX_HEIGHT);
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    r = (row_pos > h - 1) ? h - 1 : row_pos;
    p = int'(px);
    lc = (c == w - 1);
    lr = (r == h - 1);
    n0 = expected_grads.size();
    if (mode_q == MODE_X) begin
      if (c >= 1) begin
        nb = (c >= 2) ? int'(px_last2) : int'(px_last);
        expected_grads = {expected_grads, grad_entry(p - nb, r, c - 1, 1'b0)};
      end
      if (lc) begin
        // single column: the pixel is its own neighbour
        nb = (c >= 1) ? int'(px_last) : p;
        expected_grads = {expected_grads, grad_entry(p - nb, r, c, lc && lr)};
      end
    end else begin
      if (r >= 1) begin
        nb = (r >= 2) ? int'(line_above2[c]) : int'(line_above[c]);
        expected_grads = {expected_grads, grad_entry(p - nb, r - 1, c, 1'b0)};
      end
      if (lr) begin
        nb = (r >= 1) ? int'(line_above[c]) : p;
        expected_grads = {expected_grads, grad_entry(p - nb, r, c, lc && lr)};
      end
    end
    if (expected_grads.size() > n0) expected_grads[expected_grads.size() - 1].last = 1'b1;
    line_above2[c] = line_above[c];
    line_above[c]  = px;
    px_last2 = px_last;
    px_last  = px;
    if (lc) begin
      col_pos = 0;
      row_pos = lr ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix_bus.valid <= 1'b0;
      pix_bus.pixel <= '0;
      gap_left <= 0;
    end else if (!pix_bus.valid || pix_bus.ready) begin
      if (gap_left > 0) begin
        pix_bus.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_px.size() != 0) begin
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= pending_px.pop_front();
        gap_left <= idle_len();
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
  end

  // monitor: register shadow, prediction on accepted pixels, result check
  always @(posedge clk) begin
    grad_result_t exp_r;
    if (rst) begin
      grad_bus.ready <= 1'b0;
      stall_left <= 0;
      mode_q = MODE_X;
      width_q = 11'(RESET_WIDTH);
      height_q = 11'(RESET_HEIGHT);
      px_last = '0;
      px_last2 = '0;
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (reg_bus.valid && reg_bus.ready) begin
        case (reg_bus.index)
          REG_DIRECTION_MODE: mode_q = dir_mode_t'(reg_bus.data[0]);
          REG_IMAGE_WIDTH:    width_q = reg_bus.data;
          REG_IMAGE_HEIGHT:   height_q = reg_bus.data;
          default: ;
        endcase
      end
      if (pix_bus.valid && pix_bus.ready) predict_gradient(pix_bus.pixel);
      if (grad_bus.valid && grad_bus.ready) begin
        if (expected_grads.size() == 0) begin
          $error("unexpected gradient transaction at row %0d column %0d",
                 grad_bus.out_row, grad_bus.out_column);
          failed = 1'b1;
        end else begin
          exp_r = expected_grads.pop_front();
          if (grad_bus.gradient_half !== exp_r.grad) begin
            $error("gradient_half: expected %0d, got %0d", exp_r.grad, grad_bus.gradient_half);
            failed = 1'b1;
          end
          if (grad_bus.out_row !== exp_r.row) begin
            $error("out_row: expected %0d, got %0d", exp_r.row, grad_bus.out_row);
            failed = 1'b1;
          end
          if (grad_bus.out_column !== exp_r.col) begin
            $error("out_column: expected %0d, got %0d", exp_r.col, grad_bus.out_column);
            failed = 1'b1;
          end
          if (grad_bus.last_of_run !== exp_r.last) begin
            $error("last_of_run: expected %0d, got %0d", exp_r.last, grad_bus.last_of_run);
            failed = 1'b1;
          end
          if (grad_bus.frame_done !== exp_r.done) begin
            $error("frame_done: expected %0d, got %0d", exp_r.done, grad_bus.frame_done);
            failed = 1'b1;
          end
        end
      end
      if (stall_left > 0) begin
        grad_bus.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        grad_bus.ready <= 1'b1;
        stall_left <= idle_len();
      end
    end
  end

  // wait for the input to drain and every expected result to arrive
  task automatic settle();
    int waited;
    waited = 0;
    do @(negedge clk); while (pending_px.size() != 0 || pix_bus.valid);
    while (expected_grads.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    if (expected_grads.size() != 0) begin
      $error("%0d gradient results never arrived", expected_grads.size());
      failed = 1'b1;
      expected_grads.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  // set up all three registers between frames, then queue one whole frame
  task automatic run_frame(input dir_mode_t m, input logic [10:0] w, input logic [10:0] h);
    cfg_reg_t              idx[3];
    logic [CFG_DATA_W-1:0] val[3];
    int                    n;
    idx = '{REG_DIRECTION_MODE, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
    val = '{CFG_DATA_W'(m), w, h};
    n = eff_dim(w, DEF_MAX_WIDTH) * eff_dim(h, DEF_MAX_HEIGHT);
    settle();
    reg_bus.valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      reg_bus.index <= idx[i];
      reg_bus.data  <= val[i];
      do @(posedge clk); while (!reg_bus.ready);
    end
    reg_bus.valid <= 1'b0;
    @(negedge clk);
    repeat (n) pending_px = {pending_px, next_pixel()};
    directed_px.delete();
  endtask

  initial begin
    int          random_px;
    logic [10:0] w;
    logic [10:0] h;
    rst <= 1'b1;
    reg_bus.valid <= 1'b0;
    reg_bus.index <= REG_DIRECTION_MODE;
    reg_bus.data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // full-swing steps, one-sided edges, then one-column and one-row images
    directed_px = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    run_frame(MODE_X, 11'd3, 11'd2);
    directed_px = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0};
    run_frame(MODE_Y, 11'd2, 11'd3);
    directed_px = '{8'd255, 8'd0};
    run_frame(MODE_X, 11'd0, 11'd2);
    directed_px = '{8'd0, 8'd255};
    run_frame(MODE_Y, 11'd2, 11'd0);

    random_px = 0;
    while (random_px < 1034) begin
      no_idle = ($urandom_range(0, 4) == 0);
      w = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(13, 40)) : 11'($urandom_range(0, 12));
      h = 11'($urandom_range(0, 8));
      run_frame(dir_mode_t'($urandom_range(0, 1)), w, h);
      random_px += eff_dim(w, DEF_MAX_WIDTH) * eff_dim(h, DEF_MAX_HEIGHT);
    end
    no_idle = 1'b0;
    settle();

    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: central_difference_gradient.f
hdl/cdg_pkg.sv
hdl/cdg_if.sv
hdl/cdg_ram.sv
hdl/cdg_front.sv
hdl/cdg_fifo.sv
hdl/cdg_back.sv
hdl/central_difference_gradient.sv
tb/tb.sv
